[sv/sas_pkg.sv]
// Shared constants, opcodes and payload types of the sprite animation sequencer.
`default_nettype none

package sas_pkg;

  localparam int FRAME_SLOTS = 64;
  localparam int ANIM_SLOTS  = 8;
  localparam int CELL_BITS   = 10;

  localparam int SLOT_W   = $clog2(FRAME_SLOTS);
  localparam int COUNT_W  = SLOT_W + 1;
  localparam int ANIM_W   = $clog2(ANIM_SLOTS);
  localparam int PERIOD_W = 16;
  localparam int ELAPSED_W = PERIOD_W + 1;
  localparam int TEXEL_W  = 22;
  localparam int FDIM_W   = 12;
  localparam int GRID_W   = 11;

  // Shared divider sizing: the widest dividend is frame position plus quotient.
  localparam int DIV_N_W   = ELAPSED_W + 1;
  localparam int DIV_D_W   = PERIOD_W;
  localparam int DIV_CNT_W = $clog2(DIV_N_W);

  localparam logic [2:0] OP_TICK  = 3'd0;
  localparam logic [2:0] OP_LOAD  = 3'd1;
  localparam logic [2:0] OP_DESC  = 3'd2;
  localparam logic [2:0] OP_PLAY  = 3'd3;
  localparam logic [2:0] OP_STOP  = 3'd4;
  localparam logic [2:0] OP_SHOW  = 3'd5;

  localparam logic [1:0] CFG_FRAME_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_FRAME_HEIGHT = 2'd1;
  localparam logic [1:0] CFG_GRID_COLUMNS = 2'd2;
  localparam logic [1:0] CFG_GRID_ROWS    = 2'd3;

  typedef struct packed {
    logic [2:0]           opcode;
    logic [15:0]          delta;
    logic [2:0]           anim_id;
    logic [SLOT_W-1:0]    slot;
    logic [CELL_BITS-1:0] cell_index;
    logic [SLOT_W-1:0]    frame_base;
    logic [COUNT_W-1:0]   frame_count;
    logic [PERIOD_W-1:0]  frame_period;
    logic                 looping;
    logic                 restart;
    logic                 halt;
  } sas_in_t;

  typedef struct packed {
    logic [CELL_BITS-1:0] shown_cell;
    logic [TEXEL_W-1:0]   texel_left;
    logic [TEXEL_W-1:0]   texel_top;
    logic [SLOT_W-1:0]    frame_position;
    logic                 is_playing;
    logic                 end_reached;
  } sas_out_t;

  typedef struct packed {
    logic               start;
    logic [DIV_N_W-1:0] dividend;
    logic [DIV_D_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic [DIV_N_W-1:0] quotient;
    logic [DIV_D_W-1:0] remainder;
  } div_rsp_t;

endpackage

`default_nettype wire

[sv/sas_in_if.sv]
// Command channel interface of the sprite animation sequencer.
`default_nettype none

interface sas_in_if;
  import sas_pkg::*;

  logic    valid;
  logic    ready;
  sas_in_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

[sv/sas_out_if.sv]
// Result channel interface of the sprite animation sequencer.
`default_nettype none

interface sas_out_if;
  import sas_pkg::*;

  logic     valid;
  logic     ready;
  sas_out_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

[sv/sas_divider.sv]
// Shared restoring divider, one quotient bit per cycle.
`default_nettype none

module sas_divider (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire sas_pkg::div_req_t req_i,
  output sas_pkg::div_rsp_t      rsp_o
);
  import sas_pkg::*;

  logic                 busy_q;
  logic                 done_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic [DIV_N_W-1:0]   quo_q;
  logic [DIV_D_W-1:0]   rem_q;
  logic [DIV_D_W-1:0]   dsr_q;

  logic [DIV_D_W:0]     shifted;
  logic [DIV_D_W:0]     diff;
  logic                 ge;
  logic [DIV_D_W-1:0]   rem_d;

  always_comb begin
    shifted = {rem_q, quo_q[DIV_N_W-1]};
    ge      = (shifted >= {1'b0, dsr_q});
    diff    = shifted - {1'b0, dsr_q};
    rem_d   = ge ? diff[DIV_D_W-1:0] : shifted[DIV_D_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == DIV_CNT_W'(DIV_N_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      quo_q <= req_i.dividend;
      rem_q <= '0;
      dsr_q <= req_i.divisor;
    end else if (busy_q) begin
      quo_q <= {quo_q[DIV_N_W-2:0], ge};
      rem_q <= rem_d;
    end
  end

  assign rsp_o.done      = done_q;
  assign rsp_o.quotient  = quo_q;
  assign rsp_o.remainder = rem_q;

endmodule

`default_nettype wire

[sv/sprite_animation_sequencer_unit.sv]
// Top level of the sprite animation sequencer: sequencer, frame table and corner math.
// Usage:
//   Commands enter on in_ch (valid/ready); each command yields exactly one result
//   beat on out_ch carrying the shown cell, its texel corner, the frame position,
//   the playing flag and the end pulse. The user must write the geometry registers
//   through cfg_we_i/cfg_idx_i/cfg_data_i only while no command is in progress; the
//   block itself does not enforce this.
// Sequencing:
//   One command at a time. Every command ends in the corner step, whose division and
//   products an empty grid skips. An advancing tick first divides its elapsed time
//   by the period, and a wrapping one also takes the wrap modulo. Each division holds
//   the single shared divider through its quotient-bit steps and then its done flag.
//   A tick may use it for the period division and the wrap modulo, and every command
//   with a nonempty grid for the row/column split. The two corner products go through
//   one multiplier on consecutive cycles. in_ch.ready rises the cycle after the result
//   is loaded, so no command is taken before the previous result has been loaded.
// Stalls:
//   A finished result sits in the output register; the next command is accepted
//   meanwhile and its result waits until the receiver takes the pending beat.
// Reset:
//   Asynchronous, active low. Descriptors, playback state and geometry return to
//   their defaults; the frame table holds no defined contents until loaded.
`default_nettype none

module sprite_animation_sequencer_unit (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  sas_in_if.sink                       in_ch,
  sas_out_if.source                    out_ch,
  input  wire logic                    cfg_we_i,
  input  wire logic [1:0]              cfg_idx_i,
  input  wire logic [sas_pkg::FDIM_W-1:0] cfg_data_i
);
  import sas_pkg::*;

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_EXEC   = 4'd1;
  localparam logic [3:0] ST_TDIV   = 4'd2;
  localparam logic [3:0] ST_TPOS   = 4'd3;
  localparam logic [3:0] ST_TMOD   = 4'd4;
  localparam logic [3:0] ST_TREAD  = 4'd5;
  localparam logic [3:0] ST_TCELL  = 4'd6;
  localparam logic [3:0] ST_CORNER = 4'd7;
  localparam logic [3:0] ST_CDIV   = 4'd8;
  localparam logic [3:0] ST_MUL1   = 4'd9;
  localparam logic [3:0] ST_MUL2   = 4'd10;
  localparam logic [3:0] ST_OUT    = 4'd11;

  logic [3:0] state_q, state_d;

  // Geometry registers.
  logic [FDIM_W-1:0] frame_width_q, frame_height_q;
  logic [GRID_W-1:0] grid_columns_q, grid_rows_q;

  // Descriptors.
  logic [SLOT_W-1:0]   desc_base_q   [ANIM_SLOTS];
  logic [COUNT_W-1:0]  desc_count_q  [ANIM_SLOTS];
  logic [PERIOD_W-1:0] desc_period_q [ANIM_SLOTS];
  logic                desc_loop_q   [ANIM_SLOTS];

  // Playback state.
  logic [ANIM_W-1:0]    active_q;
  logic                 selected_q;
  logic                 playing_q;
  logic [ELAPSED_W-1:0] elapsed_q;
  logic [SLOT_W-1:0]    frame_cnt_q;
  logic [CELL_BITS-1:0] cell_q;
  logic                 end_q;

  // Working registers.
  sas_in_t              item_q;
  logic [DIV_N_W-1:0]   pos_q;
  logic [CELL_BITS-1:0] col_q, row_q;
  logic [TEXEL_W-1:0]   left_q, top_q;
  logic [CELL_BITS-1:0] tbl_rd_q;
  logic                 out_valid_q;
  sas_out_t             out_data_q;

  logic [CELL_BITS-1:0] frame_mem [FRAME_SLOTS];

  logic [ANIM_W-1:0]    item_id;
  logic [PERIOD_W-1:0]  act_period;
  logic [COUNT_W-1:0]   act_count;
  logic [ELAPSED_W-1:0] elapsed_sum;
  logic                 tick_live;
  logic                 tick_adv;
  logic                 pos_past;
  logic                 tbl_we;
  logic [SLOT_W-1:0]    rd_addr;
  logic [CELL_BITS-1:0] mul_a;
  logic [FDIM_W-1:0]    mul_b;
  logic [TEXEL_W-1:0]   mul_p;
  logic                 grid_empty;
  logic                 out_free;

  div_req_t div_req;
  div_rsp_t div_rsp;

  sas_divider u_divider (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  always_comb begin
    item_id     = item_q.anim_id[ANIM_W-1:0];
    act_period  = (desc_period_q[active_q] == '0) ? PERIOD_W'(1) : desc_period_q[active_q];
    act_count   = (desc_count_q[active_q] > COUNT_W'(FRAME_SLOTS)) ?
                  COUNT_W'(FRAME_SLOTS) : desc_count_q[active_q];
    elapsed_sum = elapsed_q + {1'b0, item_q.delta};
    tick_live   = playing_q && selected_q;
    tick_adv    = elapsed_sum > {1'b0, act_period};
    pos_past    = pos_q >= DIV_N_W'(act_count);
    grid_empty  = (grid_columns_q == '0) || (grid_rows_q == '0);
    out_free    = !out_valid_q || out_ch.ready;
    tbl_we      = (state_q == ST_EXEC) && (item_q.opcode == OP_LOAD);
    rd_addr     = desc_base_q[active_q] + pos_q[SLOT_W-1:0];
    mul_a       = (state_q == ST_MUL1) ? col_q : row_q;
    mul_b       = (state_q == ST_MUL1) ? frame_width_q : frame_height_q;
    mul_p       = {{(TEXEL_W-CELL_BITS){1'b0}}, mul_a} * {{(TEXEL_W-FDIM_W){1'b0}}, mul_b};
  end

  // Divider launches: period split, wrap modulo and cell row/column split.
  always_comb begin
    div_req.start    = 1'b0;
    div_req.dividend = {{(DIV_N_W-ELAPSED_W){1'b0}}, elapsed_sum};
    div_req.divisor  = act_period;
    case (state_q)
      ST_EXEC: begin
        div_req.start = (item_q.opcode == OP_TICK) && tick_live && tick_adv;
      end
      ST_TPOS: begin
        div_req.start    = pos_past && (act_count != '0) && desc_loop_q[active_q];
        div_req.dividend = pos_q;
        div_req.divisor  = DIV_D_W'(act_count);
      end
      ST_CORNER: begin
        div_req.start    = !grid_empty;
        div_req.dividend = DIV_N_W'(cell_q);
        div_req.divisor  = DIV_D_W'(grid_columns_q);
      end
      default: begin
        div_req.start = 1'b0;
      end
    endcase
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_ch.valid) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (div_req.start) begin
          state_d = ST_TDIV;
        end else begin
          state_d = ST_CORNER;
        end
      end
      ST_TDIV: begin
        if (div_rsp.done) begin
          state_d = ST_TPOS;
        end
      end
      ST_TPOS: begin
        if (pos_past && (act_count == '0)) begin
          state_d = ST_CORNER;
        end else if (div_req.start) begin
          state_d = ST_TMOD;
        end else begin
          state_d = ST_TREAD;
        end
      end
      ST_TMOD: begin
        if (div_rsp.done) begin
          state_d = ST_TREAD;
        end
      end
      ST_TREAD:  state_d = ST_TCELL;
      ST_TCELL:  state_d = ST_CORNER;
      ST_CORNER: begin
        if (grid_empty) begin
          state_d = ST_OUT;
        end else begin
          state_d = ST_CDIV;
        end
      end
      ST_CDIV: begin
        if (div_rsp.done) begin
          state_d = ST_MUL1;
        end
      end
      ST_MUL1:   state_d = ST_MUL2;
      ST_MUL2:   state_d = ST_OUT;
      ST_OUT: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default:   state_d = ST_IDLE;
    endcase
  end

  assign in_ch.ready  = (state_q == ST_IDLE);
  assign out_ch.valid = out_valid_q;
  assign out_ch.data  = out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q  <= FDIM_W'(16);
      frame_height_q <= FDIM_W'(16);
      grid_columns_q <= '0;
      grid_rows_q    <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_FRAME_WIDTH:  frame_width_q  <= cfg_data_i;
        CFG_FRAME_HEIGHT: frame_height_q <= cfg_data_i;
        CFG_GRID_COLUMNS: grid_columns_q <= cfg_data_i[GRID_W-1:0];
        CFG_GRID_ROWS:    grid_rows_q    <= cfg_data_i[GRID_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      active_q    <= '0;
      selected_q  <= 1'b0;
      playing_q   <= 1'b0;
      elapsed_q   <= '0;
      frame_cnt_q <= '0;
      cell_q      <= '0;
      end_q       <= 1'b0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < ANIM_SLOTS; i++) begin
        desc_base_q[i]   <= '0;
        desc_count_q[i]  <= '0;
        desc_period_q[i] <= PERIOD_W'(1);
        desc_loop_q[i]   <= 1'b0;
      end
    end else begin
      state_q <= state_d;
      if ((state_q == ST_OUT) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ch.ready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_EXEC: begin
          end_q <= 1'b0;
          case (item_q.opcode)
            OP_TICK: begin
              if (tick_live) begin
                elapsed_q <= elapsed_sum;
              end
            end
            OP_DESC: begin
              desc_base_q[item_id]   <= item_q.frame_base;
              desc_count_q[item_id]  <= item_q.frame_count;
              desc_period_q[item_id] <= item_q.frame_period;
              desc_loop_q[item_id]   <= item_q.looping;
            end
            OP_PLAY: begin
              elapsed_q <= '0;
              if (selected_q && (active_q == item_id) && item_q.restart) begin
                cell_q    <= '0;
                playing_q <= 1'b0;
              end else begin
                active_q    <= item_id;
                selected_q  <= 1'b1;
                frame_cnt_q <= '0;
                playing_q   <= 1'b1;
              end
            end
            OP_STOP: begin
              playing_q  <= 1'b0;
              selected_q <= 1'b0;
            end
            OP_SHOW: begin
              cell_q <= item_q.cell_index;
              if (item_q.halt) begin
                elapsed_q <= '0;
                playing_q <= 1'b0;
              end
            end
            default: begin
            end
          endcase
        end
        ST_TDIV: begin
          if (div_rsp.done) begin
            elapsed_q <= {1'b0, div_rsp.remainder};
          end
        end
        ST_TPOS: begin
          if (pos_past) begin
            end_q <= 1'b1;
            if (act_count == '0) begin
              frame_cnt_q <= '0;
              playing_q   <= 1'b0;
            end else if (!desc_loop_q[active_q]) begin
              playing_q <= 1'b0;
            end
          end
        end
        ST_TREAD: begin
          frame_cnt_q <= pos_q[SLOT_W-1:0];
        end
        ST_TCELL: begin
          cell_q <= tbl_rd_q;
        end
        default: begin
        end
      endcase
    end
  end

  // Payload and working registers.
  always_ff @(posedge clk_i) begin
    if (in_ch.valid && in_ch.ready) begin
      item_q <= in_ch.data;
    end
    if ((state_q == ST_TDIV) && div_rsp.done) begin
      pos_q <= DIV_N_W'(frame_cnt_q) + div_rsp.quotient;
    end
    if (state_q == ST_TPOS && pos_past && !desc_loop_q[active_q]) begin
      pos_q <= DIV_N_W'(act_count - 1'b1);
    end
    if ((state_q == ST_TMOD) && div_rsp.done) begin
      pos_q <= DIV_N_W'(div_rsp.remainder);
    end
    if ((state_q == ST_CDIV) && div_rsp.done) begin
      row_q <= div_rsp.quotient[CELL_BITS-1:0];
      col_q <= div_rsp.remainder[CELL_BITS-1:0];
    end
    if (state_q == ST_CORNER && grid_empty) begin
      left_q <= '0;
      top_q  <= '0;
    end
    if (state_q == ST_MUL1) begin
      left_q <= mul_p;
    end
    if (state_q == ST_MUL2) begin
      top_q <= mul_p;
    end
    if (state_q == ST_OUT && out_free) begin
      out_data_q.shown_cell     <= cell_q;
      out_data_q.texel_left     <= left_q;
      out_data_q.texel_top      <= top_q;
      out_data_q.frame_position <= frame_cnt_q;
      out_data_q.is_playing     <= playing_q;
      out_data_q.end_reached    <= end_q;
    end
  end

  // Frame table: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (tbl_we) begin
      frame_mem[item_q.slot] <= item_q.cell_index;
    end
    if (state_q == ST_TREAD) begin
      tbl_rd_q <= frame_mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

[sv/sas_checker.sv]
// Port-level checker of the sprite animation sequencer and its bind.
`default_nettype none

module sas_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_ready_i,
  input wire logic        out_valid_i,
  input wire logic        out_ready_i,
  input wire sas_pkg::sas_out_t out_data_i
);
  import sas_pkg::*;

  logic       in_beat;
  logic       out_beat;
  logic [2:0] pending_q;

  assign in_beat  = in_valid_i && in_ready_i;
  assign out_beat = out_valid_i && out_ready_i;

  // Commands accepted whose result beat has not yet been taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
    end else if (in_beat && !out_beat) begin
      pending_q <= pending_q + 1'b1;
    end else if (out_beat && !in_beat) begin
      pending_q <= pending_q - 1'b1;
    end
  end

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_beat |=> !in_ready_i)
    else $error("input ready stayed high after a command beat");

  a_no_invented_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_beat |-> (pending_q != '0))
    else $error("result beat without an outstanding command");

  a_bounded_backlog: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pending_q <= 3'd2)
    else $error("more than two commands outstanding");

  a_valid_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> out_valid_i)
    else $error("result valid dropped while stalled");

  a_data_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> $stable(out_data_i))
    else $error("result payload changed while stalled");

endmodule

bind sprite_animation_sequencer_unit sas_checker u_sas_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_ch.valid),
  .in_ready_i  (in_ch.ready),
  .out_valid_i (out_ch.valid),
  .out_ready_i (out_ch.ready),
  .out_data_i  (out_ch.data)
);

`default_nettype wire

[tb/tb_top.sv]
// Self-checking testbench for the sprite animation sequencer: a directed table, then random phases.
`timescale 1ns / 1ps

module tb_top;
  import sas_pkg::*;

  // The two opcodes left unused by the block.
  localparam logic [2:0] OP_RSVD6 = 3'd6;
  localparam logic [2:0] OP_RSVD7 = 3'd7;

  localparam int SETTLE_CYCLES = 100;
  localparam int PHASE_ITEMS   = 130;
  localparam int MAX_PRINTED   = 40;
  localparam sas_out_t BLANK   = '0;

  typedef struct {
    sas_in_t  cmd;
    bit       typed;
    sas_out_t res;
  } stim_row_t;

  logic              clk;
  logic              rst_n;
  logic              cfg_we;
  logic [1:0]        cfg_idx;
  logic [FDIM_W-1:0] cfg_data;

  sas_in_if  in_ch ();
  sas_out_if out_ch ();

  sprite_animation_sequencer_unit uut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  // Shadow copy of the sequencer state and geometry.
  logic [CELL_BITS-1:0] tbl_cell    [FRAME_SLOTS];
  logic [SLOT_W-1:0]    anim_base   [ANIM_SLOTS];
  logic [COUNT_W-1:0]   anim_len    [ANIM_SLOTS];
  logic [PERIOD_W-1:0]  anim_period [ANIM_SLOTS];
  logic                 anim_wrap   [ANIM_SLOTS];
  logic [ANIM_W-1:0]    sel_anim;
  logic                 sel_valid;
  logic                 run_flag;
  int unsigned          time_acc;
  int unsigned          frame_pos;
  logic [CELL_BITS-1:0] cell_now;
  int unsigned          geo_fw, geo_fh, geo_cols, geo_rows;

  sas_out_t  display_q [$];
  stim_row_t dir_q [$];
  logic      typed_flag;
  sas_out_t  typed_res;
  int        mismatch_count;
  int        burst_left;
  int        rx_mode = 0;
  int        rx_hold = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #(15_000_000);
    $display("tb_top: FAIL");
    $finish;
  end

  function automatic sas_in_t mk_cmd(input logic [2:0] op, input int unsigned delta, anim,
                                     slot, cell_no, base, count, period,
                                     input bit loop, restart, halt);
    sas_in_t c;
    c.opcode       = op;
    c.delta        = 16'(delta);
    c.anim_id      = 3'(anim);
    c.slot         = SLOT_W'(slot);
    c.cell_index   = CELL_BITS'(cell_no);
    c.frame_base   = SLOT_W'(base);
    c.frame_count  = COUNT_W'(count);
    c.frame_period = PERIOD_W'(period);
    c.looping      = loop;
    c.restart      = restart;
    c.halt         = halt;
    return c;
  endfunction

  function automatic sas_out_t mk_res(input int unsigned cell_no, left, top, pos,
                                      input bit play, ended);
    sas_out_t r;
    r.shown_cell     = CELL_BITS'(cell_no);
    r.texel_left     = TEXEL_W'(left);
    r.texel_top      = TEXEL_W'(top);
    r.frame_position = SLOT_W'(pos);
    r.is_playing     = play;
    r.end_reached    = ended;
    return r;
  endfunction

  function automatic sas_in_t random_bits();
    logic [95:0] raw;
    raw = {$urandom, $urandom, $urandom};
    return raw[$bits(sas_in_t)-1:0];
  endfunction

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= MAX_PRINTED) begin
      $display("tb_top: mismatch at %0t: %s", $time, msg);
    end
  endtask

  task automatic cmp_field(input string name, input int unsigned got, input int unsigned want);
    if (got != want) begin
      report_mismatch($sformatf("%s got %0d, expected %0d", name, got, want));
    end
  endtask

  // Applies one command to the shadow state and returns the beat it should produce.
  task automatic predict_display(input sas_in_t c, output sas_out_t r);
    int unsigned per, len, q, pos;
    logic        ended;
    ended = 1'b0;
    case (c.opcode)
      OP_TICK: begin
        if (run_flag && sel_valid) begin
          per = (anim_period[sel_anim] == '0) ? 1 : anim_period[sel_anim];
          len = (anim_len[sel_anim] > FRAME_SLOTS) ? FRAME_SLOTS : anim_len[sel_anim];
          time_acc = (time_acc + c.delta) & 32'h1FFFF;
          // Only a strictly greater elapsed time moves the animation.
          if (time_acc > per) begin
            q        = time_acc / per;
            time_acc = time_acc % per;
            pos      = frame_pos + q;
            if (len == 0) begin
              ended     = 1'b1;
              frame_pos = 0;
              run_flag  = 1'b0;
            end else begin
              if (pos >= len) begin
                ended = 1'b1;
                if (anim_wrap[sel_anim]) begin
                  pos = pos % len;
                end else begin
                  pos      = len - 1;
                  run_flag = 1'b0;
                end
              end
              frame_pos = pos;
              cell_now  = tbl_cell[(anim_base[sel_anim] + pos) % FRAME_SLOTS];
            end
          end
        end
      end
      OP_LOAD: begin
        tbl_cell[c.slot] = c.cell_index;
      end
      OP_DESC: begin
        anim_base[c.anim_id]   = c.frame_base;
        anim_len[c.anim_id]    = c.frame_count;
        anim_period[c.anim_id] = c.frame_period;
        anim_wrap[c.anim_id]   = c.looping;
      end
      OP_PLAY: begin
        if (sel_valid && sel_anim == c.anim_id && c.restart) begin
          cell_now = '0;
          time_acc = 0;
          run_flag = 1'b0;
        end else begin
          sel_anim  = c.anim_id;
          sel_valid = 1'b1;
          time_acc  = 0;
          frame_pos = 0;
          run_flag  = 1'b1;
        end
      end
      OP_STOP: begin
        run_flag  = 1'b0;
        sel_valid = 1'b0;
      end
      OP_SHOW: begin
        cell_now = c.cell_index;
        if (c.halt) begin
          time_acc = 0;
          run_flag = 1'b0;
        end
      end
      default: begin
      end
    endcase
    r = BLANK;
    r.shown_cell = cell_now;
    if (geo_cols != 0 && geo_rows != 0) begin
      r.texel_left = TEXEL_W'((cell_now % geo_cols) * geo_fw);
      r.texel_top  = TEXEL_W'((cell_now / geo_cols) * geo_fh);
    end
    r.frame_position = SLOT_W'(frame_pos);
    r.is_playing     = run_flag;
    r.end_reached    = ended;
  endtask

  // Random command, weighted toward play sequences whose ticks actually advance.
  task automatic draw_command(output sas_in_t c);
    int unsigned pick, per, tmp;
    c    = random_bits();
    pick = $urandom_range(0, 99);
    per  = (anim_period[sel_anim] == '0) ? 1 : anim_period[sel_anim];
    if (pick < 48) begin
      c.opcode = OP_TICK;
      case ($urandom_range(0, 3))
        0: begin
          tmp = $urandom_range(0, 3 * per);
          c.delta = (tmp > 65535) ? 16'hFFFF : 16'(tmp);
        end
        1: c.delta = 16'($urandom_range(0, 15));
        2: begin
          tmp = per + $urandom_range(0, 1);
          c.delta = (tmp > 65535) ? 16'hFFFF : 16'(tmp);
        end
        default: begin
        end
      endcase
    end else if (pick < 60) begin
      c.opcode = OP_DESC;
      case ($urandom_range(0, 9))
        0: c.frame_count = '0;
        1: c.frame_count = COUNT_W'($urandom_range(65, 127));
        2: c.frame_count = COUNT_W'($urandom_range(13, 64));
        default: c.frame_count = COUNT_W'($urandom_range(1, 12));
      endcase
      case ($urandom_range(0, 9))
        0: c.frame_period = '0;
        1: c.frame_period = 16'hFFFF;
        2: begin
        end
        default: c.frame_period = PERIOD_W'($urandom_range(1, 40));
      endcase
    end else if (pick < 72) begin
      c.opcode = OP_PLAY;
      if ($urandom_range(0, 1) == 0) begin
        c.anim_id = sel_anim;
      end
      c.restart = ($urandom_range(0, 2) == 0);
    end else if (pick < 80) begin
      c.opcode = OP_LOAD;
    end else if (pick < 88) begin
      c.opcode = OP_SHOW;
    end else if (pick < 93) begin
      c.opcode = OP_STOP;
    end else if (pick < 97) begin
      c.opcode = ($urandom_range(0, 1) == 0) ? OP_RSVD6 : OP_RSVD7;
    end else begin
      c.opcode = OP_TICK;
    end
  endtask

  // Presents one beat on the command channel; entered and left at a falling edge.
  task automatic issue(input sas_in_t c, input bit typed, input sas_out_t want);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 4);
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 8);
    end
    burst_left--;
    in_ch.valid <= 1'b1;
    in_ch.data  <= c;
    typed_flag  <= typed;
    typed_res   <= want;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    @(negedge clk);
  endtask

  task automatic settle();
    in_ch.valid <= 1'b0;
    while (display_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic program_geometry(input int unsigned fw, fh, cols, rows);
    cfg_we   <= 1'b1;
    cfg_idx  <= CFG_FRAME_WIDTH;
    cfg_data <= FDIM_W'(fw);
    @(negedge clk);
    cfg_idx  <= CFG_FRAME_HEIGHT;
    cfg_data <= FDIM_W'(fh);
    @(negedge clk);
    cfg_idx  <= CFG_GRID_COLUMNS;
    cfg_data <= FDIM_W'(cols);
    @(negedge clk);
    cfg_idx  <= CFG_GRID_ROWS;
    cfg_data <= FDIM_W'(rows);
    @(negedge clk);
    cfg_we   <= 1'b0;
    geo_fw   = fw;
    geo_fh   = fh;
    geo_cols = cols;
    geo_rows = rows;
  endtask

  // Output stalls follow a mode that changes now and then: always ready, coin flips, long holds.
  always @(negedge clk) begin
    if (rx_hold > 0) begin
      rx_hold--;
      out_ch.ready <= 1'b0;
    end else begin
      case (rx_mode)
        0: out_ch.ready <= 1'b1;
        1: out_ch.ready <= 1'($urandom_range(0, 1));
        default: begin
          out_ch.ready <= 1'b1;
          if ($urandom_range(0, 9) == 0) begin
            rx_hold = $urandom_range(1, 30);
          end
        end
      endcase
      if ($urandom_range(0, 149) == 0) begin
        rx_mode = $urandom_range(0, 2);
      end
    end
  end

  // Result beats are checked before the command of the same edge is predicted.
  always @(posedge clk) begin
    sas_out_t want, pred;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        if (display_q.size() == 0) begin
          report_mismatch("result beat with no command pending");
        end else begin
          want = display_q.pop_front();
          cmp_field("shown_cell", out_ch.data.shown_cell, want.shown_cell);
          cmp_field("texel_left", out_ch.data.texel_left, want.texel_left);
          cmp_field("texel_top", out_ch.data.texel_top, want.texel_top);
          cmp_field("frame_position", out_ch.data.frame_position, want.frame_position);
          cmp_field("is_playing", out_ch.data.is_playing, want.is_playing);
          cmp_field("end_reached", out_ch.data.end_reached, want.end_reached);
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        predict_display(in_ch.data, pred);
        display_q.push_back(typed_flag ? typed_res : pred);
      end
    end
  end

  initial begin
    sas_in_t     c;
    int unsigned fw, fh, cols, rows;
    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_idx        = CFG_FRAME_WIDTH;
    cfg_data       = '0;
    in_ch.valid    = 1'b0;
    in_ch.data     = '0;
    out_ch.ready   = 1'b0;
    typed_flag     = 1'b0;
    typed_res      = BLANK;
    mismatch_count = 0;
    burst_left     = 0;
    for (int i = 0; i < FRAME_SLOTS; i++) tbl_cell[i] = '0;
    for (int i = 0; i < ANIM_SLOTS; i++) begin
      anim_base[i]   = '0;
      anim_len[i]    = '0;
      anim_period[i] = PERIOD_W'(1);
      anim_wrap[i]   = 1'b0;
    end
    sel_anim  = '0;
    sel_valid = 1'b0;
    run_flag  = 1'b0;
    time_acc  = 0;
    frame_pos = 0;
    cell_now  = '0;
    geo_fw    = 16;
    geo_fh    = 16;
    geo_cols  = 0;
    geo_rows  = 0;

    // Directed rows run on the reset geometry, so every corner is zero.
    dir_q.push_back('{mk_cmd(OP_TICK, 16'hFFFF, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1, BLANK});
    dir_q.push_back('{mk_cmd(OP_RSVD6, 16'hFFFF, 7, 63, 1023, 63, 127, 16'hFFFF, 1, 1, 1),
                      1'b1, BLANK});
    dir_q.push_back('{mk_cmd(OP_RSVD7, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1, BLANK});
    // Descriptor 0 is empty after reset: the first advancing tick ends and stops.
    dir_q.push_back('{mk_cmd(OP_PLAY, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1,
                      mk_res(0, 0, 0, 0, 1, 0)});
    dir_q.push_back('{mk_cmd(OP_TICK, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1,
                      mk_res(0, 0, 0, 0, 1, 0)});
    dir_q.push_back('{mk_cmd(OP_TICK, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1,
                      mk_res(0, 0, 0, 0, 0, 1)});
    dir_q.push_back('{mk_cmd(OP_LOAD, 0, 0, 0, 1023, 0, 0, 0, 0, 0, 0), 1'b1, BLANK});
    dir_q.push_back('{mk_cmd(OP_LOAD, 0, 0, 63, 5, 0, 0, 0, 0, 0, 0), 1'b1, BLANK});
    dir_q.push_back('{mk_cmd(OP_LOAD, 0, 0, 1, 341, 0, 0, 0, 0, 0, 0), 1'b1, BLANK});
    dir_q.push_back('{mk_cmd(OP_LOAD, 0, 0, 2, 682, 0, 0, 0, 0, 0, 0), 1'b1, BLANK});
    // Zero period, base at the top slot so the table index wraps.
    dir_q.push_back('{mk_cmd(OP_DESC, 0, 7, 0, 0, 63, 3, 0, 1, 0, 0), 1'b1, BLANK});
    dir_q.push_back('{mk_cmd(OP_PLAY, 0, 7, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1,
                      mk_res(0, 0, 0, 0, 1, 0)});
    dir_q.push_back('{mk_cmd(OP_TICK, 5, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0, BLANK});
    dir_q.push_back('{mk_cmd(OP_PLAY, 0, 7, 0, 0, 0, 0, 0, 0, 1, 0), 1'b1,
                      mk_res(0, 0, 0, 2, 0, 0)});
    dir_q.push_back('{mk_cmd(OP_SHOW, 0, 0, 0, 1023, 0, 0, 0, 0, 0, 0), 1'b1,
                      mk_res(1023, 0, 0, 2, 0, 0)});
    // A count above the table size clamps to the full table.
    dir_q.push_back('{mk_cmd(OP_DESC, 0, 3, 0, 0, 0, 127, 1, 0, 0, 0), 1'b0, BLANK});
    dir_q.push_back('{mk_cmd(OP_PLAY, 0, 3, 0, 0, 0, 0, 0, 0, 1, 0), 1'b0, BLANK});
    dir_q.push_back('{mk_cmd(OP_TICK, 16'hFFFF, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0, BLANK});
    dir_q.push_back('{mk_cmd(OP_DESC, 0, 0, 0, 0, 1, 2, 16'hFFFF, 0, 0, 0), 1'b0, BLANK});
    dir_q.push_back('{mk_cmd(OP_PLAY, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0, BLANK});
    dir_q.push_back('{mk_cmd(OP_TICK, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0, BLANK});
    dir_q.push_back('{mk_cmd(OP_TICK, 16'hFFFF, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0, BLANK});
    dir_q.push_back('{mk_cmd(OP_TICK, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0, BLANK});
    dir_q.push_back('{mk_cmd(OP_SHOW, 0, 0, 0, 7, 0, 0, 0, 0, 0, 1), 1'b0, BLANK});
    dir_q.push_back('{mk_cmd(OP_STOP, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0, BLANK});
    dir_q.push_back('{mk_cmd(OP_PLAY, 0, 0, 0, 0, 0, 0, 0, 0, 1, 0), 1'b0, BLANK});

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    foreach (dir_q[i]) issue(dir_q[i].cmd, dir_q[i].typed, dir_q[i].res);

    for (int ph = 0; ph < 6; ph++) begin
      fw   = $urandom_range(1, 4095);
      fh   = $urandom_range(1, 4095);
      cols = $urandom_range(1, 1024);
      rows = $urandom_range(1, 1024);
      case (ph)
        0: begin
          fw = 16; fh = 16; cols = 8; rows = 8;
        end
        1: begin
          fw = 1; fh = 1; cols = 1; rows = 1;
        end
        2: begin
          fw = 4095; fh = 4095; cols = 1024; rows = 1024;
        end
        3: rows = 0;
        4: cols = 0;
        default: begin
        end
      endcase
      settle();
      program_geometry(fw, fh, cols, rows);
      // Fill the whole frame table first so no tick can ever reach an unloaded slot.
      if (ph == 0) begin
        for (int s = 0; s < FRAME_SLOTS; s++) begin
          c        = random_bits();
          c.opcode = OP_LOAD;
          c.slot   = SLOT_W'(s);
          issue(c, 1'b0, BLANK);
        end
      end
      repeat (PHASE_ITEMS) begin
        draw_command(c);
        issue(c, 1'b0, BLANK);
      end
    end

    settle();
    if (display_q.size() != 0) begin
      report_mismatch($sformatf("%0d results never arrived", display_q.size()));
    end
    if (mismatch_count == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule

[files.f]
sv/sas_pkg.sv
sv/sas_in_if.sv
sv/sas_out_if.sv
sv/sas_divider.sv
sv/sprite_animation_sequencer_unit.sv
sv/sas_checker.sv
tb/tb_top.sv
